[sv/stereo_tone_control_chain_macros.svh]
// Assertion macros shared by the tone control checker.
`ifndef STEREO_TONE_CONTROL_CHAIN_MACROS_SVH
`define STEREO_TONE_CONTROL_CHAIN_MACROS_SVH

// Check a same-cycle implication at every clock edge outside reset.
`define STCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication whose consequence is checked in the next cycle.
`define STCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/stcc_pkg.sv]
// Types, constants and helper functions of the stereo tone control chain.
`timescale 1ns / 1ps
`default_nettype none
package stcc_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int SLOT_W     = 3;
	localparam int COEF_W     = 20;
	localparam int SIG_W      = 44;
	localparam int DLY_W      = 48;
	localparam int SUM_W      = 50;
	localparam int HALF_W     = 22;
	localparam int MUL_W      = 32;
	localparam int ACC_W      = 64;
	localparam int PEAK_W     = 23;
	localparam int CNT_W      = 13;
	localparam int FS100_W    = 30;
	localparam int LIM_W      = 46;
	localparam int NUM_W      = 28;
	localparam int PRE_GAIN_W = 17;
	localparam int VOL_W      = 7;
	localparam int B_REG_W    = 60;
	localparam int A_REG_W    = 40;
	localparam int BITS_W     = 5;
	localparam int FEAT_W     = 4;
	localparam int CFG_DATA_W = 60;
	localparam int CFG_IDX_W  = 3;

	// Clip count saturates at 4096
	localparam logic [CNT_W-1:0] CLIP_CAP = 13'd4096;
	localparam logic [VOL_W-1:0] VOL_MAX  = 7'd100;
	// Half of 100 * 2^16, rounding offset of the volume rescale
	localparam logic [21:0] VOL_HALF = 22'd3276800;
	// ceil(2^36 / 100), exact for dividends below 2^30
	localparam logic signed [MUL_W-1:0] RECIP_100 = 32'sd687194768;
	// ceil(2^33 / 25), exact for dividends below 2^30
	localparam logic signed [MUL_W-1:0] RECIP_25  = 32'sd343597384;

	// Feature enable bits
	localparam int FE_LOW   = 0;
	localparam int FE_HIGH  = 1;
	localparam int FE_METER = 2;
	localparam int FE_CLIP  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		RI_PRE_GAIN,
		RI_VOLUME,
		RI_LO_B,
		RI_LO_A,
		RI_HI_B,
		RI_HI_A,
		RI_BITS,
		RI_FEAT
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAIN,
		ST_GSAT,
		ST_SHELF,
		ST_VOL_HI,
		ST_VOL_LO,
		ST_VOL_MAG,
		ST_DIV,
		ST_DIV_FIX,
		ST_AVG,
		ST_AVG_FIX,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic en;
		logic cont;
	} mac_ctl_t;

	typedef struct packed {
		logic clr_low;
		logic clr_high;
	} dly_clr_t;

	typedef struct packed {
		logic [PRE_GAIN_W-1:0] pre_gain;
		logic [VOL_W-1:0]      volume;
		logic [B_REG_W-1:0]    lo_b;
		logic [A_REG_W-1:0]    lo_a;
		logic [B_REG_W-1:0]    hi_b;
		logic [A_REG_W-1:0]    hi_a;
		logic [BITS_W-1:0]     sample_bits;
		logic [FEAT_W-1:0]     features;
	} cfg_t;

	// Saturate a wide sum to the signal width
	function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:SIG_W-1] == {(SUM_W-SIG_W+1){v[SUM_W-1]}})
			return v[SIG_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(SIG_W-1){1'b0}}};
		else
			return {1'b0, {(SIG_W-1){1'b1}}};
	endfunction

	// Saturate a wide sum to the delay width
	function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:DLY_W-1] == {(SUM_W-DLY_W+1){v[SUM_W-1]}})
			return v[DLY_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(DLY_W-1){1'b0}}};
		else
			return {1'b0, {(DLY_W-1){1'b1}}};
	endfunction

	// Drop 16 fraction bits, rounding half away from zero
	function automatic logic signed [DLY_W-1:0] round_scale(input logic signed [ACC_W-1:0] p);
		logic signed [ACC_W-1:0] r;
		r = p + (p[ACC_W-1] ? 64'sd32767 : 64'sd32768);
		return r[ACC_W-1:16];
	endfunction

endpackage
`default_nettype wire

[sv/stcc_mac.sv]
// Shared multiply-accumulate unit with a registered rounding stage.
`timescale 1ns / 1ps
`default_nettype none
module stcc_mac (
	input  logic                          clk,
	input  stcc_pkg::mac_ctl_t            ctl,
	input  logic signed [31:0]            a,
	input  logic signed [31:0]            b,
	output logic signed [63:0]            acc_q,
	output logic signed [47:0]            rnd_q
);
	import stcc_pkg::*;

	logic signed [ACC_W-1:0] prod;

	assign prod = a * b;

	// Start a product, or shift the upper partial and add the lower one
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.cont)
				acc_q <= (acc_q <<< HALF_W) + prod;
			else
				acc_q <= prod;
		end
		rnd_q <= round_scale(acc_q);
	end

endmodule
`default_nettype wire

[sv/stcc_core.sv]
// Sequencer, datapath, shelf delays and block meter of the tone control chain.
`timescale 1ns / 1ps
`default_nettype none
module stcc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stcc_pkg::cfg_t       cfg,
	input  stcc_pkg::dly_clr_t   clr,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [23:0]          in_sample,
	input  logic [2:0]           in_slot,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [23:0]          out_sample,
	output logic                 out_done,
	output logic [22:0]          out_peak,
	output logic [22:0]          out_smooth,
	output logic                 out_clip,
	output logic [12:0]          out_count
);
	import stcc_pkg::*;

	st_t st_q, st_d;
	logic [3:0] cnt_q;
	logic       shelf_q, side_q, last_q;

	logic [SAMPLE_W-1:0]      x_q;
	logic signed [SIG_W-1:0]  v_q, y_q;
	logic signed [DLY_W-1:0]  t1_q, t2_q;
	logic                     neg_q, clip_q;
	logic [FS100_W-1:0]       s_q;
	logic [PEAK_W-1:0]        fs_q;
	logic [LIM_W-1:0]         lim_q;
	logic signed [DLY_W-1:0]  delay_q [8];

	logic [PEAK_W-1:0] rp_q, avg_q;
	logic [CNT_W-1:0]  tally_q;
	logic              flag_q;

	logic [SAMPLE_W-1:0] res_sample_q;
	logic                res_done_q, res_clip_q;
	logic [PEAK_W-1:0]   res_peak_q, res_smooth_q;
	logic [CNT_W-1:0]    res_count_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic                out_done_q, out_clip_q;
	logic [PEAK_W-1:0]   out_peak_q, out_smooth_q;
	logic [CNT_W-1:0]    out_count_q;

	mac_ctl_t                mac_ctl;
	logic signed [MUL_W-1:0] mac_a, mac_b;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DLY_W-1:0] rnd_q;

	logic signed [SIG_W-1:0] src;
	logic [MUL_W-1:0]        src_hi, src_lo;
	logic [B_REG_W-1:0]      b_reg;
	logic [A_REG_W-1:0]      a_reg;
	logic [COEF_W-1:0]       coef;
	logic [VOL_W-1:0]        vol_eff;
	logic [BITS_W-1:0]       bits_eff;
	logic [SAMPLE_W-1:0]     fs_wide;
	logic [PEAK_W-1:0]       fs_new;
	logic [FS100_W-1:0]      fs100;
	logic [2:0]              rd_addr;
	logic signed [DLY_W-1:0] d_rd;
	logic [50:0]             mag;
	logic [51:0]             tsum;
	logic                    clip_now;
	logic [PEAK_W-1:0]       q;
	logic [NUM_W-1:0]        num;
	logic [PEAK_W-1:0]       avg_new;
	logic                    load_out;
	logic                    accept;

	stcc_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.a     (mac_a),
		.b     (mac_b),
		.acc_q (acc_q),
		.rnd_q (rnd_q)
	);

	assign accept   = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign load_out = (st_q == ST_FIN) && (!out_valid_q || out_ready);

	// Clamp the sample width and derive full scale and the clip limit
	always_comb begin
		bits_eff = cfg.sample_bits;
		if (bits_eff < 5'd8)
			bits_eff = 5'd8;
		if (bits_eff > 5'(SAMPLE_W))
			bits_eff = 5'(SAMPLE_W);
		fs_wide = (24'd1 << (bits_eff - 5'd1)) - 24'd1;
		fs_new  = fs_wide[PEAK_W-1:0];
		fs100   = {1'b0, fs_new, 6'b0} + {2'b0, fs_new, 5'b0} + {5'b0, fs_new, 2'b0};
	end

	// Pick coefficient and operand halves for the multiplier
	always_comb begin
		b_reg   = shelf_q ? cfg.hi_b : cfg.lo_b;
		a_reg   = shelf_q ? cfg.hi_a : cfg.lo_a;
		src     = (cnt_q < 4'd6 || st_q != ST_SHELF) ? v_q : y_q;
		src_hi  = {{(MUL_W-HALF_W){src[SIG_W-1]}}, src[SIG_W-1:HALF_W]};
		src_lo  = {{(MUL_W-HALF_W){1'b0}}, src[HALF_W-1:0]};
		vol_eff = (cfg.volume > VOL_MAX) ? VOL_MAX : cfg.volume;
		num     = {2'b0, avg_q, 3'b0} + {1'b0, rp_q, 4'b0} + {5'b0, rp_q} + 28'd12;
		case (cnt_q[3:1])
			3'd0:    coef = b_reg[COEF_W-1:0];
			3'd1:    coef = b_reg[2*COEF_W-1:COEF_W];
			3'd2:    coef = b_reg[3*COEF_W-1:2*COEF_W];
			3'd3:    coef = a_reg[COEF_W-1:0];
			3'd4:    coef = a_reg[2*COEF_W-1:COEF_W];
			default: coef = '0;
		endcase
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (st_q)
			ST_GAIN: begin
				mac_ctl.en = 1'b1;
				mac_a = {{(MUL_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
				mac_b = {{(MUL_W-PRE_GAIN_W){1'b0}}, cfg.pre_gain};
			end
			ST_SHELF: begin
				mac_ctl.en   = (cnt_q <= 4'd9);
				mac_ctl.cont = cnt_q[0];
				mac_a = {{(MUL_W-COEF_W){coef[COEF_W-1]}}, coef};
				mac_b = cnt_q[0] ? src_lo : src_hi;
			end
			ST_VOL_HI: begin
				mac_ctl.en = 1'b1;
				mac_a = {{(MUL_W-VOL_W){1'b0}}, vol_eff};
				mac_b = src_hi;
			end
			ST_VOL_LO: begin
				mac_ctl.en   = 1'b1;
				mac_ctl.cont = 1'b1;
				mac_a = {{(MUL_W-VOL_W){1'b0}}, vol_eff};
				mac_b = src_lo;
			end
			ST_DIV: begin
				mac_ctl.en = 1'b1;
				mac_a = {{(MUL_W-FS100_W){1'b0}}, s_q};
				mac_b = RECIP_100;
			end
			ST_AVG: begin
				mac_ctl.en = 1'b1;
				mac_a = {{(MUL_W-NUM_W){1'b0}}, num};
				mac_b = RECIP_25;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	// Delay read port, clip test and quotient pick
	always_comb begin
		rd_addr  = {shelf_q, side_q, (cnt_q == 4'd9)};
		d_rd     = delay_q[rd_addr];
		mag      = acc_q[ACC_W-1] ? 51'(-acc_q) : acc_q[50:0];
		clip_now = mag > {5'b0, lim_q};
		tsum     = {1'b0, mag} + {30'b0, VOL_HALF};
		q        = clip_q ? fs_q : acc_q[58:36];
		avg_new  = acc_q[55:33];
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:    if (in_valid) st_d = ST_GAIN;
			ST_GAIN:    st_d = ST_GSAT;
			ST_GSAT: begin
				if (cfg.features[FE_LOW] || cfg.features[FE_HIGH])
					st_d = ST_SHELF;
				else
					st_d = ST_VOL_HI;
			end
			ST_SHELF: begin
				if (cnt_q == 4'd11 && (shelf_q || !cfg.features[FE_HIGH]))
					st_d = ST_VOL_HI;
			end
			ST_VOL_HI:  st_d = ST_VOL_LO;
			ST_VOL_LO:  st_d = ST_VOL_MAG;
			ST_VOL_MAG: st_d = ST_DIV;
			ST_DIV:     st_d = ST_DIV_FIX;
			ST_DIV_FIX: st_d = last_q ? ST_AVG : ST_FIN;
			ST_AVG:     st_d = ST_AVG_FIX;
			ST_AVG_FIX: st_d = ST_FIN;
			ST_FIN:     if (load_out) st_d = ST_IDLE;
			default:    st_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	// Step counter, shelf select, meter state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			shelf_q     <= 1'b0;
			rp_q        <= '0;
			avg_q       <= '0;
			tally_q     <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_GSAT: begin
					cnt_q   <= '0;
					shelf_q <= !cfg.features[FE_LOW];
				end
				ST_SHELF: begin
					if (cnt_q == 4'd11) begin
						cnt_q   <= '0;
						shelf_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_VOL_MAG: begin
					if (clip_now && cfg.features[FE_CLIP]) begin
						flag_q <= 1'b1;
						if (tally_q < CLIP_CAP)
							tally_q <= tally_q + 13'd1;
					end
				end
				ST_DIV_FIX: begin
					if (cfg.features[FE_METER] && q > rp_q)
						rp_q <= q;
				end
				ST_AVG_FIX: begin
					avg_q   <= avg_new;
					rp_q    <= '0;
					tally_q <= '0;
					flag_q  <= 1'b0;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Shelf delays: clear on coefficient writes, update at the end of each shelf
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				delay_q[i] <= '0;
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (clr.clr_low)
					delay_q[i] <= '0;
				if (clr.clr_high)
					delay_q[i+4] <= '0;
			end
			if (st_q == ST_SHELF && cnt_q == 4'd9)
				delay_q[{shelf_q, side_q, 1'b0}] <=
					sat_dly(50'(t1_q) - 50'(rnd_q) + 50'(d_rd));
			if (st_q == ST_SHELF && cnt_q == 4'd11)
				delay_q[{shelf_q, side_q, 1'b1}] <= sat_dly(50'(t2_q) - 50'(rnd_q));
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_sample;
			side_q <= |in_slot;
			last_q <= in_last;
			fs_q   <= fs_new;
			lim_q  <= {fs100, 16'b0};
		end
		case (st_q)
			ST_GSAT: v_q <= acc_q[SIG_W-1:0];
			ST_SHELF: begin
				case (cnt_q)
					4'd3:    y_q  <= sat_sig(50'(rnd_q) + 50'(d_rd));
					4'd5:    t1_q <= rnd_q;
					4'd7:    t2_q <= rnd_q;
					4'd11:   v_q  <= y_q;
					default: t1_q <= t1_q;
				endcase
			end
			ST_VOL_MAG: begin
				neg_q  <= acc_q[ACC_W-1];
				clip_q <= clip_now;
				s_q    <= tsum[45:16];
			end
			ST_DIV_FIX: begin
				res_sample_q <= neg_q ? (24'd0 - {1'b0, q}) : {1'b0, q};
				res_done_q   <= 1'b0;
				res_peak_q   <= '0;
				res_smooth_q <= '0;
				res_clip_q   <= 1'b0;
				res_count_q  <= '0;
			end
			ST_AVG_FIX: begin
				res_done_q   <= 1'b1;
				res_peak_q   <= rp_q;
				res_smooth_q <= avg_new;
				res_clip_q   <= flag_q;
				res_count_q  <= tally_q;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_sample_q <= res_sample_q;
			out_done_q   <= res_done_q;
			out_peak_q   <= res_peak_q;
			out_smooth_q <= res_smooth_q;
			out_clip_q   <= res_clip_q;
			out_count_q  <= res_count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_done   = out_done_q;
	assign out_peak   = out_peak_q;
	assign out_smooth = out_smooth_q;
	assign out_clip   = out_clip_q;
	assign out_count  = out_count_q;

endmodule
`default_nettype wire

[sv/stereo_tone_control_chain.sv]
// Top level of the stereo tone control chain: register file, core and stream ports.
//
//  channel | direction | signals                                   | beat
//  s_*     | in        | tvalid tready tdata tuser tlast           | one PCM sample
//  m_*     | out       | tvalid tready tdata tuser tlast           | one processed sample
//  cfg_*   | in        | cfg_valid cfg_ready cfg_index cfg_data    | one register write
//
//  A new sample is taken only once the core is idle again; each enabled
//  shelf and a block end add steps on the shared multiplier.
//  The result sits in an output register while the next sample is taken;
//  a stalled output holds the core in its final step until the beat leaves.
//  Reset clears all filter delays, meter state and valid flags.
`timescale 1ns / 1ps
`default_nettype none
module stereo_tone_control_chain (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] sample_in
	input  logic [2:0]  s_tuser,   // [2:0] channel_slot
	input  logic        s_tlast,   // block_end
	output logic        m_tvalid,
	input  logic        m_tready,
	// [23:0] sample_out, [46:24] block_peak, [69:47] avg_peak, [82:70] clip_count
	output logic [87:0] m_tdata,
	output logic [0:0]  m_tuser,   // [0] clip_seen
	output logic        m_tlast,   // block_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_data
);
	import stcc_pkg::*;

	cfg_t     cfg_q;
	dly_clr_t clr;
	logic     cfg_we;

	logic [SAMPLE_W-1:0] out_sample;
	logic                out_done, out_clip;
	logic [PEAK_W-1:0]   out_peak, out_smooth;
	logic [CNT_W-1:0]    out_count;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Clear a shelf's delays when its coefficients are written
	always_comb begin
		clr.clr_low  = cfg_we && (cfg_index == RI_LO_B || cfg_index == RI_LO_A);
		clr.clr_high = cfg_we && (cfg_index == RI_HI_B || cfg_index == RI_HI_A);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_gain    <= 17'd65536;
			cfg_q.volume      <= 7'd100;
			cfg_q.lo_b        <= 60'd65536;
			cfg_q.lo_a        <= '0;
			cfg_q.hi_b        <= 60'd65536;
			cfg_q.hi_a        <= '0;
			cfg_q.sample_bits <= 5'd16;
			cfg_q.features    <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				RI_PRE_GAIN: cfg_q.pre_gain    <= cfg_data[PRE_GAIN_W-1:0];
				RI_VOLUME:   cfg_q.volume      <= cfg_data[VOL_W-1:0];
				RI_LO_B:     cfg_q.lo_b        <= cfg_data[B_REG_W-1:0];
				RI_LO_A:     cfg_q.lo_a        <= cfg_data[A_REG_W-1:0];
				RI_HI_B:     cfg_q.hi_b        <= cfg_data[B_REG_W-1:0];
				RI_HI_A:     cfg_q.hi_a        <= cfg_data[A_REG_W-1:0];
				RI_BITS:     cfg_q.sample_bits <= cfg_data[BITS_W-1:0];
				RI_FEAT:     cfg_q.features    <= cfg_data[FEAT_W-1:0];
				default:     cfg_q.features    <= cfg_q.features;
			endcase
		end
	end

	stcc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.clr        (clr),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_sample  (s_tdata[SAMPLE_W-1:0]),
		.in_slot    (s_tuser),
		.in_last    (s_tlast),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sample (out_sample),
		.out_done   (out_done),
		.out_peak   (out_peak),
		.out_smooth (out_smooth),
		.out_clip   (out_clip),
		.out_count  (out_count)
	);

	// Pack the result beat
	assign m_tdata = {5'b0, out_count, out_smooth, out_peak, out_sample};
	assign m_tuser = out_clip;
	assign m_tlast = out_done;

endmodule
`default_nettype wire

[sv/stcc_checker.sv]
// Port-level checker of the stereo tone control chain and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_tone_control_chain_macros.svh"
module stcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// A taken sample keeps the input closed while it is processed
	`STCC_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "input open after beat")

	// A stalled result beat holds
	`STCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed under stall")

	// Meter fields stay zero off block end
	`STCC_ASSERT_NOW(a_meter_zero, m_tvalid && !m_tlast, m_tuser == 1'b0 && m_tdata[82:24] == '0, "meter fields set off block end")

	// Clip flag agrees with clip count on a block end
	`STCC_ASSERT_NOW(a_clip_pair, m_tvalid && m_tlast, m_tuser[0] == (m_tdata[82:70] != 13'd0), "clip flag and count disagree")

endmodule

bind stereo_tone_control_chain stcc_checker u_stcc_checker (.*);
`default_nettype wire

[dv/stereo_tone_control_chain_test.sv]
// Testbench for the stereo tone control chain: random stream traffic checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module stereo_tone_control_chain_test;
	import stcc_pkg::*;

	typedef struct {
		logic [23:0] sample;
		logic [2:0]  slot;
		logic        last;
	} pcm_beat_t;

	typedef struct {
		logic [23:0] sample;
		logic        done;
		logic [22:0] peak;
		logic [22:0] smooth;
		logic        clip;
		logic [12:0] count;
	} tone_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [59:0] cfg_data = '0;

	stereo_tone_control_chain u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	logic [16:0] p_gain;
	logic [6:0] p_vol;
	logic [59:0] p_lo_b, p_hi_b;
	logic [39:0] p_lo_a, p_hi_a;
	logic [4:0] p_bits;
	logic [3:0] p_feat;
	longint p_delay[8];
	longint p_run_peak, p_avg, p_tally;
	bit p_clip;

	pcm_beat_t pending_beats[$];
	tone_result_t expected_results[$];
	int mismatches = 0;
	bit quiet = 1'b0;    // no idling while set

	function automatic longint sat_to(longint v, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint coef_at(logic [59:0] r, int k);
		logic signed [19:0] f;
		f = r[20*k +: 20];
		return longint'(f);
	endfunction

	function automatic longint rescale_coef(longint p);
		longint m;
		m = p < 0 ? -p : p;
		m = (m + 32768) >>> 16;
		return p < 0 ? -m : m;
	endfunction

	function automatic longint shelf_filter(longint v, logic [59:0] br, logic [39:0] ar,
			int base);
		longint y;
		y = sat_to(rescale_coef(coef_at(br, 0) * v) + p_delay[base], 44);
		p_delay[base] = sat_to(rescale_coef(coef_at(br, 1) * v)
			- rescale_coef(coef_at({20'd0, ar}, 0) * y) + p_delay[base+1], 48);
		p_delay[base+1] = sat_to(rescale_coef(coef_at(br, 2) * v)
			- rescale_coef(coef_at({20'd0, ar}, 1) * y), 48);
		return y;
	endfunction

	function automatic void reset_predictor();
		p_gain = 17'd65536; p_vol = 7'd100;
		p_lo_b = 60'd65536; p_hi_b = 60'd65536; p_lo_a = '0; p_hi_a = '0;
		p_bits = 5'd16; p_feat = '0;
		foreach (p_delay[i]) p_delay[i] = 0;
		p_run_peak = 0; p_avg = 0; p_tally = 0; p_clip = 0;
	endfunction

	function automatic void apply_register(reg_idx_t idx, logic [59:0] val);
		case (idx)
			RI_PRE_GAIN: p_gain = val[16:0];
			RI_VOLUME: p_vol = val[6:0];
			RI_LO_B: begin p_lo_b = val; for (int i = 0; i < 4; i++) p_delay[i] = 0; end
			RI_LO_A: begin p_lo_a = val[39:0]; for (int i = 0; i < 4; i++) p_delay[i] = 0; end
			RI_HI_B: begin p_hi_b = val; for (int i = 4; i < 8; i++) p_delay[i] = 0; end
			RI_HI_A: begin p_hi_a = val[39:0]; for (int i = 4; i < 8; i++) p_delay[i] = 0; end
			RI_BITS: p_bits = val[4:0];
			RI_FEAT: p_feat = val[3:0];
			default: ;
		endcase
	endfunction

	function automatic tone_result_t predict_result(pcm_beat_t b);
		tone_result_t r;
		longint x, v, y, fs, mag, q, bits, vol;
		int side;
		logic signed [23:0] sx;
		sx = b.sample;
		x = longint'(sx);
		side = (b.slot != 0) ? 2 : 0;
		bits = p_bits < 8 ? 8 : (p_bits > 24 ? 24 : p_bits);
		vol = p_vol > 100 ? 100 : p_vol;
		fs = (64'sd1 <<< (bits - 1)) - 1;
		v = sat_to(x * longint'(p_gain), 44);
		if (p_feat[FE_LOW]) v = shelf_filter(v, p_lo_b, p_lo_a, side);
		if (p_feat[FE_HIGH]) v = shelf_filter(v, p_hi_b, p_hi_a, 4 + side);
		y = v * vol;
		mag = y < 0 ? -y : y;
		if (mag > fs * 6553600) begin
			q = fs;
			if (p_feat[FE_CLIP]) begin
				p_clip = 1;
				if (p_tally < 4096) p_tally++;
			end
		end else
			q = (mag + 3276800) / 6553600;
		if (p_feat[FE_METER] && q > p_run_peak) p_run_peak = q;
		r.sample = y < 0 ? 24'(-q) : 24'(q);
		r.done = 0; r.peak = '0; r.smooth = '0; r.clip = 0; r.count = '0;
		if (b.last) begin
			p_avg = (8 * p_avg + 17 * p_run_peak + 12) / 25;
			r.done = 1;
			r.peak = 23'(p_run_peak);
			r.smooth = 23'(p_avg);
			r.clip = p_clip;
			r.count = 13'(p_tally);
			p_run_peak = 0; p_tally = 0; p_clip = 0;
		end
		return r;
	endfunction

	// Drive sample beats from the pending queue
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_result('{s_tdata, s_tuser, s_tlast}));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_beats[0].sample;
					s_tuser <= pending_beats[0].slot;
					s_tlast <= pending_beats[0].last;
					void'(pending_beats.pop_front());
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the output at random and check each result beat
	always @(posedge clk) begin
		tone_result_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[23:0] !== e.sample || m_tlast !== e.done
							|| m_tdata[46:24] !== e.peak || m_tdata[69:47] !== e.smooth
							|| m_tuser[0] !== e.clip || m_tdata[82:70] !== e.count
							|| m_tdata[87:83] !== 5'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp s=%h d=%b pk=%h sm=%h c=%b n=%0d got s=%h d=%b pk=%h sm=%h c=%b n=%0d",
								e.sample, e.done, e.peak, e.smooth, e.clip, e.count,
								m_tdata[23:0], m_tlast, m_tdata[46:24], m_tdata[69:47],
								m_tuser[0], m_tdata[82:70]);
					end
				end
			end
			m_tready <= quiet || $urandom_range(99) >= 21;
		end
	end

	task automatic write_register(reg_idx_t idx, logic [59:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_beats.size() == 0 && !s_tvalid && expected_results.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [19:0] rand_coef(int spread);
		return 20'($signed($urandom_range(2*spread)) - spread);
	endfunction

	task automatic queue_samples(int n, int blk);
		pcm_beat_t b;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: b.sample = 24'h7FFFFF;
				1: b.sample = 24'h800000;
				2: b.sample = 24'($signed($urandom_range(511)) - 256);
				default: b.sample = 24'($urandom);
			endcase
			b.slot = (i % 2 == 0) ? 3'd0 : 3'($urandom_range(1, 7));
			b.last = ($urandom_range(blk - 1) == 0);
			pending_beats.push_back(b);
		end
	endtask

	// Stimulus: directed corners, then random phases over several settings
	initial begin
		logic [59:0] bq;
		logic [39:0] aq;
		reset_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// Reset settings: unity chain, meter off
		pending_beats.push_back('{24'h7FFFFF, 3'd0, 1'b0});
		pending_beats.push_back('{24'h800000, 3'd1, 1'b1});
		drain();
		write_register(RI_FEAT, 60'hF);
		write_register(RI_BITS, 60'd24);
		pending_beats.push_back('{24'h7FFFFF, 3'd0, 1'b0});
		pending_beats.push_back('{24'h800000, 3'd7, 1'b0});
		pending_beats.push_back('{24'h000001, 3'd2, 1'b0});
		pending_beats.push_back('{24'hFFFFFF, 3'd4, 1'b1});
		drain();
		// Out of range width and volume, zero gain, full gain at zero volume, clip at narrow width
		write_register(RI_BITS, 60'd0);
		write_register(RI_VOLUME, 60'd127);
		pending_beats.push_back('{24'h7FFFFF, 3'd0, 1'b0});
		pending_beats.push_back('{24'h0000C0, 3'd3, 1'b1});
		drain();
		write_register(RI_BITS, 60'd31);
		write_register(RI_PRE_GAIN, 60'd0);
		pending_beats.push_back('{24'h7FFFFF, 3'd0, 1'b1});
		drain();
		write_register(RI_PRE_GAIN, 60'h1FFFF);
		write_register(RI_VOLUME, 60'd0);
		pending_beats.push_back('{24'h800000, 3'd5, 1'b1});
		drain();
		// Random phases
		for (int ph = 0; ph < 12; ph++) begin
			write_register(RI_PRE_GAIN, ph == 1 ? 60'd65536 : 60'($urandom_range(65536)));
			write_register(RI_VOLUME, ph == 2 ? 60'd100 : 60'($urandom_range(127)));
			bq = {rand_coef(ph % 3 == 0 ? 524287 : 30000), rand_coef(40000),
				20'd40000 + rand_coef(30000)};
			write_register(RI_LO_B, bq);
			aq = {rand_coef(ph % 4 == 0 ? 524287 : 20000), rand_coef(30000)};
			write_register(RI_LO_A, {20'd0, aq});
			write_register(RI_HI_B, ph == 5 ? 60'hFFFFFFFFFFFFFFF : 60'({$urandom, $urandom}));
			write_register(RI_HI_A, ph == 6 ? 60'hFFFFFFFFFF : 60'({rand_coef(30000),
				rand_coef(30000)}));
			write_register(RI_BITS, 60'($urandom_range(31)));
			write_register(RI_FEAT, 60'(ph % 16 == 0 ? 15 : $urandom_range(15)));
			quiet = (ph == 7);
			queue_samples(78, ph % 2 ? 8 : 40);
			drain();
		end
		quiet = 1'b0;
		pending_beats.push_back('{24'h0, 3'd0, 1'b1});
		drain();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
